// ===== hw/rtl/fps_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fps_pkg: shared definitions of the frame pacing scheduler
// Widths, event and action codes, constants, and the command and status
// bundles that join the controller and the datapath.
// ============================================================================
package fps_pkg;

    // Sizing.
    localparam int TIME_BITS        = 48;
    localparam int MAX_RATE_MHZ     = 240000;
    localparam int FAST_FRAME_LIMIT = 3;
    localparam int TGT_W            = $clog2(MAX_RATE_MHZ + 1);
    localparam int FCNT_W           = $clog2(FAST_FRAME_LIMIT + 1);
    localparam int DIV_W            = 64;
    localparam int DVS_W            = TIME_BITS;
    localparam int IV_W             = 30;
    localparam int RATE_W           = 20;
    localparam int WCNT_W           = 16;
    localparam int MODE_W           = 3;
    localparam int OP_W             = 3;
    localparam int ACT_W            = 2;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 20;

    // Event codes.
    localparam logic [OP_W-1:0] OP_SWAP    = 3'd0;
    localparam logic [OP_W-1:0] OP_TIMER   = 3'd1;
    localparam logic [OP_W-1:0] OP_REEVAL  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REQ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ARM  = 2'd2;

    // Pacing modes.
    localparam logic [MODE_W-1:0] MODE_UNBOUNDED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISPLAY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FPS60     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FPS90     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FPS120    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FPS144    = 3'd6;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PACING_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH     = 1'd1;

    // Constants.
    localparam logic [DIV_W-1:0]      NS_PER_KS     = 64'd1000000000000;
    localparam logic [TIME_BITS-1:0]  NS_PER_S      = TIME_BITS'(1000000000);
    localparam logic [IV_W-1:0]       MAX_DELAY     = 30'd1000000000;
    localparam logic [RATE_W-1:0]     MFPS_MAX      = 20'hFFFFF;
    localparam logic [RATE_W-1:0]     REFRESH_DFLT  = 20'd60000;
    localparam logic [RATE_W-1:0]     RATE_MIN      = 20'd1000;
    localparam logic [RATE_W-1:0]     RATE_MAX      = RATE_W'(MAX_RATE_MHZ);
    localparam logic [RATE_W-1:0]     MEAS_HYST     = 20'd50;
    localparam logic [WCNT_W-1:0]     WCNT_MAX      = 16'hFFFF;
    localparam logic [FCNT_W-1:0]     FCNT_LIMIT    = FCNT_W'(FAST_FRAME_LIMIT);

    // Divider operand selection.
    typedef enum logic [1:0] {
        DSEL_IV,
        DSEL_MEAS,
        DSEL_REM
    } div_sel_t;

    // Controller to datapath.
    typedef struct packed {
        logic             load;
        logic             reeval;
        logic             restart;
        logic             stop;
        logic             meas;
        logic             mul;
        logic             div_start;
        div_sel_t         div_sel;
        logic             take_iv;
        logic             take_meas;
        logic             take_rem;
        logic             fast;
        logic             sched_base;
        logic             sched_final;
        logic             finish;
        logic [ACT_W-1:0] act;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            run;
        logic            active;
        logic            mode_unb;
        logic            latched;
        logic            fast_ok;
        logic            last_nz;
        logic            iv_ok;
        logic            t_zero;
        logic            close;
        logic            fast_hit;
        logic            d_le_now;
        logic            div_done;
        logic            out_free;
    } stat_t;

endpackage

// ===== hw/rtl/fps_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fps_div: serial restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ============================================================================
module fps_div
    import fps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // One restoring step.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/fps_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fps_datapath: pacing state, configuration and arithmetic
// Holds the timing state and the result register, and runs the divider.
// ============================================================================
module fps_datapath
    import fps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 st,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [OP_W-1:0]       in_op,
    input  logic [TIME_BITS-1:0]  in_now,
    input  logic                  in_may_run,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ACT_W-1:0]      out_action,
    output logic [IV_W-1:0]       out_delay,
    output logic [RATE_W-1:0]     out_mfps,
    output logic                  out_active,
    output logic                  out_limited
);

    // Configuration and pacing state.
    logic [MODE_W-1:0]    mode_reg;
    logic [RATE_W-1:0]    refresh_reg;
    logic                 active_reg;
    logic [TIME_BITS-1:0] deadline_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_BITS-1:0] ws_reg;
    logic [WCNT_W-1:0]    wcnt_reg;
    logic [FCNT_W-1:0]    fcnt_reg;
    logic                 latched_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [IV_W-1:0]      iv_reg;
    logic                 iv_ok_reg;
    logic                 out_valid_reg;

    // Working registers.
    logic [OP_W-1:0]      op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 run_reg;
    logic [WCNT_W-1:0]    mcnt_reg;
    logic [TIME_BITS-1:0] el_reg;
    logic [DIV_W-1:0]     prod_reg;
    logic [TIME_BITS:0]   d_reg;
    logic [IV_W-1:0]      dly_reg;
    logic [ACT_W-1:0]     oact_reg;
    logic [IV_W-1:0]      odly_reg;
    logic [RATE_W-1:0]    omfps_reg;
    logic                 oact_flag_reg;
    logic                 olim_reg;

    logic [TGT_W-1:0]     tgt;
    logic [RATE_W-1:0]    disp;
    logic [27:0]          tgt_x100;
    logic [27:0]          disp_x95;
    logic [TIME_BITS-1:0] ws_eff;
    logic [WCNT_W-1:0]    wcnt_eff;
    logic [WCNT_W-1:0]    wcnt_inc;
    logic [TIME_BITS:0]   elapsed;
    logic                 close;
    logic [TIME_BITS+1:0] gap_x4;
    logic [TIME_BITS+1:0] iv_x3;
    logic                 fast;
    logic [FCNT_W-1:0]    fcnt_new;
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS:0]   dl_span;
    logic [RATE_W-1:0]    meas_v;
    logic [RATE_W-1:0]    rate_zero;
    logic                 div_start;
    logic [DIV_W-1:0]     div_a;
    logic [DVS_W-1:0]     div_b;
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;
    logic [DVS_W-1:0]     div_r;

    // The stored rate moves only on a change of at least the hysteresis.
    function automatic logic [RATE_W-1:0] rate_pick(input logic [RATE_W-1:0] cur,
                                                    input logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] diff;
        diff = (cur > v) ? cur - v : v - cur;
        return (diff >= MEAS_HYST) ? v : cur;
    endfunction

    // Target rate from the mode.
    always_comb
    begin
        unique case (mode_reg)
            MODE_DISPLAY:
            begin
                if (refresh_reg == '0)
                    tgt = TGT_W'(REFRESH_DFLT);
                else if (refresh_reg < RATE_MIN)
                    tgt = TGT_W'(RATE_MIN);
                else if (refresh_reg > RATE_MAX)
                    tgt = TGT_W'(RATE_MAX);
                else
                    tgt = TGT_W'(refresh_reg);
            end
            MODE_FPS60:  tgt = TGT_W'(60000);
            MODE_FPS90:  tgt = TGT_W'(90000);
            MODE_FPS120: tgt = TGT_W'(120000);
            MODE_FPS144: tgt = TGT_W'(144000);
            default:     tgt = '0;
        endcase
    end

    // Fast-path test against 95% of the display rate.
    assign disp     = (refresh_reg == '0) ? REFRESH_DFLT : refresh_reg;
    assign tgt_x100 = 28'(tgt) * 28'd100;
    assign disp_x95 = 28'(disp) * 28'd95;

    // Measurement window.
    assign ws_eff   = (ws_reg == '0) ? now_reg : ws_reg;
    assign wcnt_eff = (ws_reg == '0) ? '0 : wcnt_reg;
    assign wcnt_inc = (wcnt_eff == WCNT_MAX) ? wcnt_eff : wcnt_eff + 1'b1;
    assign elapsed  = {1'b0, now_reg} - {1'b0, ws_eff};
    assign close    = !elapsed[TIME_BITS] && (elapsed[TIME_BITS-1:0] >= NS_PER_S);

    // Swap spacing against 3/4 of the interval.
    assign gap_x4   = {2'b00, now_reg - last_reg} << 2;
    assign iv_x3    = (TIME_BITS+2)'(iv_reg) * (TIME_BITS+2)'(3);
    assign fast     = (now_reg < last_reg) || (gap_x4 < iv_x3);
    always_comb
    begin
        if (last_reg == '0)
            fcnt_new = fcnt_reg;
        else if (!fast)
            fcnt_new = '0;
        else if (fcnt_reg < FCNT_LIMIT)
            fcnt_new = fcnt_reg + 1'b1;
        else
            fcnt_new = fcnt_reg;
    end

    // Schedule helpers.
    assign base      = (deadline_reg == '0) ? now_reg : deadline_reg;
    assign dl_span   = d_reg - {1'b0, now_reg};
    assign meas_v    = (div_q > DIV_W'(MFPS_MAX)) ? MFPS_MAX : div_q[RATE_W-1:0];
    assign rate_zero = rate_pick(rate_reg, '0);

    // Divider operands.
    assign div_start = cmd.div_start;
    always_comb
    begin
        unique case (cmd.div_sel)
            DSEL_IV:
            begin
                div_a = NS_PER_KS + DIV_W'(tgt >> 1);
                div_b = DVS_W'(tgt);
            end
            DSEL_MEAS:
            begin
                div_a = prod_reg + DIV_W'(el_reg >> 1);
                div_b = el_reg;
            end
            DSEL_REM:
            begin
                div_a = DIV_W'(now_reg - d_reg[TIME_BITS-1:0]);
                div_b = DVS_W'(iv_reg);
            end
            default:
            begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    fps_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Pacing state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            refresh_reg   <= REFRESH_DFLT;
            active_reg    <= 1'b0;
            deadline_reg  <= '0;
            last_reg      <= '0;
            ws_reg        <= '0;
            wcnt_reg      <= '0;
            fcnt_reg      <= '0;
            latched_reg   <= 1'b0;
            rate_reg      <= '0;
            iv_reg        <= '0;
            iv_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                iv_ok_reg <= 1'b0;
                unique case (cfg_idx)
                    CFG_PACING_MODE: mode_reg    <= cfg_wdata[MODE_W-1:0];
                    CFG_REFRESH:     refresh_reg <= cfg_wdata;
                    default:         mode_reg    <= mode_reg;
                endcase
            end

            // Start, stop and restart clear the deadline, window and swap state.
            if (cmd.stop || cmd.restart || (cmd.reeval && !(run_reg && active_reg)))
            begin
                deadline_reg <= '0;
                last_reg     <= '0;
                ws_reg       <= '0;
                wcnt_reg     <= '0;
                fcnt_reg     <= '0;
                latched_reg  <= 1'b0;
                rate_reg     <= rate_zero;
                active_reg   <= (cmd.stop) ? 1'b0 : run_reg;
            end
            else if (cmd.meas)
            begin
                if (close)
                begin
                    ws_reg   <= now_reg;
                    wcnt_reg <= '0;
                end
                else
                begin
                    ws_reg   <= ws_eff;
                    wcnt_reg <= wcnt_inc;
                end
            end
            else if (cmd.take_meas)
            begin
                rate_reg <= rate_pick(rate_reg, meas_v);
            end
            else if (cmd.take_iv)
            begin
                iv_reg    <= div_q[IV_W-1:0];
                iv_ok_reg <= 1'b1;
            end
            else if (cmd.fast)
            begin
                fcnt_reg <= fcnt_new;
                last_reg <= now_reg;
                if (fcnt_new >= FCNT_LIMIT)
                    latched_reg <= 1'b1;
            end
            else if (cmd.sched_final)
            begin
                deadline_reg <= d_reg[TIME_BITS-1:0];
            end

            // Result register.
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Per-event working values.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            now_reg <= in_now;
            run_reg <= in_may_run && (mode_reg != '0);
        end
        if (cmd.meas)
        begin
            mcnt_reg <= wcnt_inc;
            el_reg   <= elapsed[TIME_BITS-1:0];
        end
        if (cmd.mul)
            prod_reg <= DIV_W'(mcnt_reg) * NS_PER_KS;
        if (cmd.sched_base)
            d_reg <= {1'b0, base} + (TIME_BITS+1)'(iv_reg);
        else if (cmd.take_rem)
            d_reg <= {1'b0, now_reg} + (TIME_BITS+1)'(iv_reg)
                     - (TIME_BITS+1)'(div_r[IV_W-1:0]);
        if (cmd.sched_final)
            dly_reg <= (dl_span > (TIME_BITS+1)'(MAX_DELAY)) ? MAX_DELAY
                                                             : dl_span[IV_W-1:0];
        if (cmd.finish)
        begin
            oact_reg      <= cmd.act;
            odly_reg      <= (cmd.act == ACT_ARM) ? dly_reg : '0;
            omfps_reg     <= rate_reg;
            oact_flag_reg <= active_reg;
            olim_reg      <= latched_reg;
        end
    end

    // Status to the controller.
    always_comb
    begin
        st.op       = op_reg;
        st.run      = run_reg;
        st.active   = active_reg;
        st.mode_unb = mode_reg == MODE_UNBOUNDED;
        st.latched  = latched_reg;
        st.fast_ok  = tgt_x100 >= disp_x95;
        st.last_nz  = last_reg != '0;
        st.iv_ok    = iv_ok_reg;
        st.t_zero   = tgt == '0;
        st.close    = close;
        st.fast_hit = fcnt_new >= FCNT_LIMIT;
        st.d_le_now = d_reg <= {1'b0, now_reg};
        st.div_done = div_done;
        st.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_action  = oact_reg;
    assign out_delay   = odly_reg;
    assign out_mfps    = omfps_reg;
    assign out_active  = oact_flag_reg;
    assign out_limited = olim_reg;

endmodule

// ===== hw/rtl/fps_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fps_ctrl: event sequencer of the frame pacing scheduler
// Walks one event through measurement, fast-path and schedule steps.
// ============================================================================
module fps_ctrl
    import fps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_MEAS     = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_MDIV     = 4'd4;
    localparam logic [3:0] S_MWAIT    = 4'd5;
    localparam logic [3:0] S_DECIDE   = 4'd6;
    localparam logic [3:0] S_IV       = 4'd7;
    localparam logic [3:0] S_IVWAIT   = 4'd8;
    localparam logic [3:0] S_FAST     = 4'd9;
    localparam logic [3:0] S_SCHED    = 4'd10;
    localparam logic [3:0] S_SCHK     = 4'd11;
    localparam logic [3:0] S_RWAIT    = 4'd12;
    localparam logic [3:0] S_FINAL    = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [ACT_W-1:0] act_reg, act_next;
    logic             to_fast_reg, to_fast_next;

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        to_fast_next = to_fast_reg;
        cmd          = '0;
        cmd.div_sel  = DSEL_IV;
        cmd.act      = act_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                act_next   = ACT_NONE;
                if ((st.op == OP_SWAP) && st.active && st.run)
                    state_next = S_MEAS;
                else if ((st.op == OP_TIMER) && st.active && st.run)
                    act_next = ACT_REQ;
                else if ((st.op == OP_SWAP) || (st.op == OP_TIMER) ||
                         (st.op == OP_REEVAL))
                begin
                    cmd.reeval = 1'b1;
                    act_next   = (st.run && !st.active) ? ACT_REQ : ACT_NONE;
                end
                else if (st.op == OP_RESTART)
                begin
                    cmd.restart = 1'b1;
                    act_next    = st.run ? ACT_REQ : ACT_NONE;
                end
                else if (st.op == OP_STOP)
                    cmd.stop = 1'b1;
            end
            S_MEAS:
            begin
                cmd.meas   = 1'b1;
                state_next = st.close ? S_MUL : S_DECIDE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_MEAS;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (st.div_done)
                begin
                    cmd.take_meas = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st.mode_unb)
                begin
                    act_next   = ACT_REQ;
                    state_next = S_DONE;
                end
                else if (!st.latched && st.fast_ok)
                begin
                    to_fast_next = 1'b1;
                    state_next   = (st.last_nz && !st.iv_ok) ? S_IV : S_FAST;
                end
                else
                    state_next = S_SCHED;
            end
            S_IV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_IV;
                state_next    = S_IVWAIT;
            end
            S_IVWAIT:
            begin
                if (st.div_done)
                begin
                    cmd.take_iv = 1'b1;
                    state_next  = to_fast_reg ? S_FAST : S_SCHED;
                end
            end
            S_FAST:
            begin
                cmd.fast     = 1'b1;
                to_fast_next = 1'b0;
                if (st.fast_hit)
                    state_next = S_SCHED;
                else
                begin
                    act_next   = ACT_REQ;
                    state_next = S_DONE;
                end
            end
            S_SCHED:
            begin
                to_fast_next = 1'b0;
                if (st.t_zero)
                begin
                    cmd.stop   = 1'b1;
                    act_next   = ACT_NONE;
                    state_next = S_DONE;
                end
                else if (!st.iv_ok)
                    state_next = S_IV;
                else
                begin
                    cmd.sched_base = 1'b1;
                    state_next     = S_SCHK;
                end
            end
            S_SCHK:
            begin
                // A missed deadline skips forward by whole intervals.
                if (st.d_le_now)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_REM;
                    state_next    = S_RWAIT;
                end
                else
                    state_next = S_FINAL;
            end
            S_RWAIT:
            begin
                if (st.div_done)
                begin
                    cmd.take_rem = 1'b1;
                    state_next   = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.sched_final = 1'b1;
                act_next        = ACT_ARM;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            act_reg     <= ACT_NONE;
            to_fast_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            act_reg     <= act_next;
            to_fast_reg <= to_fast_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

// ===== hw/rtl/frame_pacing_scheduler_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frame_pacing_scheduler_top: frame pacing scheduler
// Takes timestamped pacing events and answers with one action per event.
// ============================================================================
// One event is handled at a time and gives exactly one result beat. Simple
// events (timer, reevaluate, restart, stop) go straight from dispatch to the
// result. A frame swap also runs the single shared 64-step serial divider
// when the one-second measurement window closes, when the frame interval must
// be recomputed (first schedule after a configuration write), and when a
// missed deadline is skipped. The result sits in an output register, so the
// next event is taken while it waits.
module frame_pacing_scheduler_top
    import fps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [TIME_BITS-1:0]  now_ns,
    input  logic                  may_run,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ACT_W-1:0]      action,
    output logic [IV_W-1:0]       delay_ns,
    output logic [RATE_W-1:0]     measured_mfps,
    output logic                  is_active,
    output logic                  rate_limited,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t st;

    // Configuration writes are taken at any time.
    assign cfg_ready = 1'b1;

    fps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    fps_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_wdata   (cfg_data),
        .in_op       (opcode),
        .in_now      (now_ns),
        .in_may_run  (may_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_action  (action),
        .out_delay   (delay_ns),
        .out_mfps    (measured_mfps),
        .out_active  (is_active),
        .out_limited (rate_limited)
    );

endmodule
